/* rtl/ccts_pkg.sv */
// ============================================================================
// ccts_pkg
// Shared types and constants for the conveyor camera trigger sequencer.
// ============================================================================
package ccts_pkg;

   // Camera stations along the conveyor
   localparam int STAGES     = 4;
   localparam int STAGE_BITS = 2;
   localparam logic [STAGE_BITS-1:0] LAST_STAGE = 2'd3;

   // Register widths
   localparam int DELAY_BITS = 24;
   localparam int PULSE_BITS = 16;

   // Configuration register indices
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_ONE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_TWO   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_THREE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_FOUR  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_WIDTH = 3'd4;

   // Register reset values and the pulse timer limit
   localparam logic [DELAY_BITS-1:0] DELAY_RESET = 24'd1000;
   localparam logic [PULSE_BITS-1:0] PULSE_RESET = 16'd100;
   localparam logic [PULSE_BITS-1:0] PULSE_MAX   = 16'hFFFF;

   // Payload widths
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 48;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_PULSE,
      ST_RESULT
   } state_type;

   // Phase strobes from the sequencer to the datapath
   typedef struct packed {
      logic req_ready;
      logic prime;
      logic scan;
      logic pulse;
      logic load_rsp;
   } ctrl_type;

endpackage

/* rtl/ccts_ram.sv */
// ============================================================================
// ccts_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ccts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ccts_timer_unit.sv */
// ============================================================================
// ccts_timer_unit
// Shared saturating timer advance and expiry compare.
// ============================================================================
module ccts_timer_unit #(
   parameter int WIDTH = 24
) (
   input  logic [WIDTH-1:0] value,
   input  logic [WIDTH-1:0] limit,
   input  logic [WIDTH-1:0] threshold,
   input  logic             advance,
   output logic [WIDTH-1:0] next_value,
   output logic             expired
);

   // Advance by one unless saturated, then compare against the threshold
   always_comb begin
      if (advance && (value < limit)) begin
         next_value = value + 1'b1;
      end else begin
         next_value = value;
      end
      expired = (next_value >= threshold);
   end

endmodule

/* rtl/ccts_ctrl.sv */
// ============================================================================
// ccts_ctrl
// Sequencer that walks every stage and every slot timer once per running tick.
// ============================================================================
module ccts_ctrl #(
   parameter int SLOTS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_fire,
   input  logic                                   req_running,
   input  logic                                   rsp_busy,
   output ccts_pkg::ctrl_type                     ctrl,
   output logic [ccts_pkg::STAGE_BITS-1:0]        stage,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] slot_idx,
   output logic [$clog2(ccts_pkg::STAGES*SLOTS)-1:0]  flat_idx
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int AW = $clog2(ccts_pkg::STAGES * SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   ccts_pkg::state_type state_ff, state_in;
   logic [ccts_pkg::STAGE_BITS-1:0] stage_ff, stage_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [AW-1:0] flat_ff, flat_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ccts_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = req_running ? ccts_pkg::ST_PRIME : ccts_pkg::ST_RESULT;
            end
         end
         ccts_pkg::ST_PRIME: begin
            state_in = ccts_pkg::ST_SCAN;
         end
         ccts_pkg::ST_SCAN: begin
            if (slot_ff == LAST_SLOT) begin
               state_in = ccts_pkg::ST_PULSE;
            end
         end
         ccts_pkg::ST_PULSE: begin
            state_in = (stage_ff == ccts_pkg::LAST_STAGE) ? ccts_pkg::ST_RESULT
                                                          : ccts_pkg::ST_PRIME;
         end
         ccts_pkg::ST_RESULT: begin
            if (!rsp_busy) begin
               state_in = ccts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ccts_pkg::ST_IDLE;
         end
      endcase
   end

   // Counters
   always_comb begin
      stage_in = stage_ff;
      slot_in  = slot_ff;
      flat_in  = flat_ff;
      case (state_ff)
         ccts_pkg::ST_IDLE: begin
            stage_in = '0;
            slot_in  = '0;
            flat_in  = '0;
         end
         ccts_pkg::ST_SCAN: begin
            slot_in = (slot_ff == LAST_SLOT) ? '0 : SW'(slot_ff + 1'b1);
            flat_in = AW'(flat_ff + 1'b1);
         end
         ccts_pkg::ST_PULSE: begin
            stage_in = ccts_pkg::STAGE_BITS'(stage_ff + 1'b1);
         end
         default: begin
         end
      endcase
   end

   // Phase strobes
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ccts_pkg::ST_IDLE:   ctrl.req_ready = 1'b1;
         ccts_pkg::ST_PRIME:  ctrl.prime     = 1'b1;
         ccts_pkg::ST_SCAN:   ctrl.scan      = 1'b1;
         ccts_pkg::ST_PULSE:  ctrl.pulse     = 1'b1;
         ccts_pkg::ST_RESULT: ctrl.load_rsp  = !rsp_busy;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccts_pkg::ST_IDLE;
         stage_ff <= '0;
         slot_ff  <= '0;
         flat_ff  <= '0;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
         slot_ff  <= slot_in;
         flat_ff  <= flat_in;
      end
   end

   assign stage    = stage_ff;
   assign slot_idx = slot_ff;
   assign flat_idx = flat_ff;

endmodule

/* rtl/conveyor_camera_trigger_sequencer_top.sv */
// ============================================================================
// conveyor_camera_trigger_sequencer_top
// Four-station camera trigger sequencer driven by one timebase tick per
// transaction.
// ============================================================================
// Each request transaction is one timebase tick. A running tick passes from
// acceptance through, per stage, a prime state, a scan of every slot timer and
// a pulse state, then the response load. The single timer unit advances and
// checks one slot per cycle as the slot timers stream out of the elapsed-count
// RAM. A tick with running low goes straight from acceptance to the response
// load. The request side is ready only when the block is idle; a finished
// response waits in the output register until it is taken.
// ============================================================================
module conveyor_camera_trigger_sequencer_top #(
   parameter int SLOTS      = 8,
   parameter int TIMER_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request: [0] sensor_rise, [1] running, [7:2] zero
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ccts_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // Response: [3:0] camera_triggers, [4] object_done, [36:5] completed_total,
   // [40:37] slot_conflict, [47:41] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ccts_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // Configuration write port
   input  logic                                  csr_we,
   input  logic [ccts_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ccts_pkg::DELAY_BITS-1:0]       csr_data
);

   localparam int STAGES = ccts_pkg::STAGES;
   localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int AW     = $clog2(STAGES * SLOTS);
   localparam int DEPTH  = STAGES * SLOTS;
   localparam int UW     = (TIMER_BITS > ccts_pkg::DELAY_BITS) ? TIMER_BITS
                                                               : ccts_pkg::DELAY_BITS;
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   ccts_pkg::ctrl_type ctrl;
   logic [ccts_pkg::STAGE_BITS-1:0] stage;
   logic [SW-1:0] slot_idx;
   logic [AW-1:0] flat_idx;

   logic req_fire;
   logic rsp_busy;

   // Configuration registers
   logic [ccts_pkg::DELAY_BITS-1:0] delay_ff [STAGES];
   logic [ccts_pkg::PULSE_BITS-1:0] pulse_width_ff;

   // Tracking state
   logic [DEPTH-1:0]                 busy_ff;
   logic [SW-1:0]                    queue_ff      [STAGES];
   logic [STAGES-1:0]                pulse_act_ff;
   logic [ccts_pkg::PULSE_BITS-1:0]  pulse_el_ff   [STAGES];
   logic [31:0]                      completed_ff;

   // Per-tick working registers
   logic              running_ff;
   logic              claim_pend_ff;
   logic              claim_valid_ff;
   logic [SW-1:0]     claim_slot_ff;
   logic              fired_ff;
   logic              done_ff;
   logic [STAGES-1:0] conflict_ff;

   // Response registers
   logic        rsp_valid_ff;
   logic [3:0]  rsp_trig_ff;
   logic        rsp_done_ff;
   logic [31:0] rsp_total_ff;
   logic [3:0]  rsp_conflict_ff;

   // Shared timer unit
   logic [UW-1:0] unit_value;
   logic [UW-1:0] unit_limit;
   logic [UW-1:0] unit_threshold;
   logic          unit_advance;
   logic [UW-1:0] unit_next;
   logic          unit_expired;

   // Elapsed-count RAM
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [TIMER_BITS-1:0] ram_rd_data;

   // Datapath helpers
   logic [AW-1:0] claim_idx;
   logic          claimed;
   logic          slot_live;
   logic          pulse_live;
   logic          pulse_end;

   assign req_fire   = req_tvalid && ctrl.req_ready;
   assign rsp_busy   = rsp_valid_ff && !rsp_tready;
   assign req_tready = ctrl.req_ready;

   ccts_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_running (req_tdata[1]),
      .rsp_busy    (rsp_busy),
      .ctrl        (ctrl),
      .stage       (stage),
      .slot_idx    (slot_idx),
      .flat_idx    (flat_idx)
   );

   // Slot being claimed in the current stage and its RAM slot under scan
   assign claim_idx  = AW'(flat_idx + AW'(queue_ff[stage]));
   assign claimed    = claim_valid_ff && (slot_idx == claim_slot_ff);
   assign slot_live  = busy_ff[flat_idx] || claimed;
   assign pulse_live = pulse_act_ff[stage] || fired_ff;
   assign pulse_end  = pulse_live && unit_expired;

   // Select the timer unit operands for the current phase
   always_comb begin
      unit_value     = '0;
      unit_limit     = UW'(ccts_pkg::PULSE_MAX);
      unit_threshold = '0;
      unit_advance   = 1'b0;
      if (ctrl.prime) begin
         unit_value   = UW'(pulse_el_ff[stage]);
         unit_advance = pulse_act_ff[stage];
      end else if (ctrl.scan) begin
         unit_value     = claimed ? '0 : UW'(ram_rd_data);
         unit_limit     = UW'(TIMER_MAX);
         unit_threshold = UW'(delay_ff[stage]);
         unit_advance   = !claimed;
      end else if (ctrl.pulse) begin
         unit_value     = fired_ff ? '0 : UW'(pulse_el_ff[stage]);
         unit_threshold = UW'(pulse_width_ff);
      end
   end

   ccts_timer_unit #(
      .WIDTH (UW)
   ) u_timer (
      .value      (unit_value),
      .limit      (unit_limit),
      .threshold  (unit_threshold),
      .advance    (unit_advance),
      .next_value (unit_next),
      .expired    (unit_expired)
   );

   // Stream the stage's slots out of the RAM one ahead of the scan
   assign ram_rd_en   = ctrl.prime || (ctrl.scan && (slot_idx != LAST_SLOT));
   assign ram_rd_addr = ctrl.prime ? flat_idx : AW'(flat_idx + 1'b1);
   assign ram_wr_en   = ctrl.scan && slot_live && !unit_expired;

   ccts_ram #(
      .WIDTH (TIMER_BITS),
      .DEPTH (DEPTH)
   ) u_elapsed_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (flat_idx),
      .wr_data (unit_next[TIMER_BITS-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            delay_ff[i] <= ccts_pkg::DELAY_RESET;
         end
         pulse_width_ff <= ccts_pkg::PULSE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ccts_pkg::CSR_DELAY_ONE:   delay_ff[0]    <= csr_data;
            ccts_pkg::CSR_DELAY_TWO:   delay_ff[1]    <= csr_data;
            ccts_pkg::CSR_DELAY_THREE: delay_ff[2]    <= csr_data;
            ccts_pkg::CSR_DELAY_FOUR:  delay_ff[3]    <= csr_data;
            ccts_pkg::CSR_PULSE_WIDTH: pulse_width_ff <= csr_data[ccts_pkg::PULSE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Tick processing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= '0;
         pulse_act_ff   <= '0;
         completed_ff   <= '0;
         running_ff     <= 1'b0;
         claim_pend_ff  <= 1'b0;
         claim_valid_ff <= 1'b0;
         claim_slot_ff  <= '0;
         fired_ff       <= 1'b0;
         done_ff        <= 1'b0;
         conflict_ff    <= '0;
         for (int i = 0; i < STAGES; i++) begin
            queue_ff[i]    <= '0;
            pulse_el_ff[i] <= '0;
         end
      end else begin
         // Latch the tick and arm the stage-one claim from the sensor edge
         if (req_fire) begin
            running_ff    <= req_tdata[1];
            claim_pend_ff <= req_tdata[0];
            done_ff       <= 1'b0;
            conflict_ff   <= '0;
         end

         // Advance the stage's pulse timer and resolve the pending claim
         if (ctrl.prime) begin
            pulse_el_ff[stage] <= unit_next[ccts_pkg::PULSE_BITS-1:0];
            fired_ff           <= 1'b0;
            claim_slot_ff      <= queue_ff[stage];
            claim_valid_ff     <= 1'b0;
            if (claim_pend_ff) begin
               if (busy_ff[claim_idx]) begin
                  conflict_ff[stage] <= 1'b1;
               end else begin
                  claim_valid_ff  <= 1'b1;
                  queue_ff[stage] <= (queue_ff[stage] == LAST_SLOT) ? '0
                                     : SW'(queue_ff[stage] + 1'b1);
               end
            end
         end

         // Advance one slot timer and fire the camera when it expires
         if (ctrl.scan && slot_live) begin
            busy_ff[flat_idx] <= !unit_expired;
            if (unit_expired) begin
               fired_ff <= 1'b1;
            end
         end

         // End the pulse and hand the object to the next stage
         if (ctrl.pulse) begin
            pulse_act_ff[stage] <= pulse_live && !unit_expired;
            pulse_el_ff[stage]  <= unit_value[ccts_pkg::PULSE_BITS-1:0];
            claim_pend_ff       <= pulse_end && (stage != ccts_pkg::LAST_STAGE);
            if (pulse_end && (stage == ccts_pkg::LAST_STAGE)) begin
               completed_ff <= completed_ff + 1'b1;
               done_ff      <= 1'b1;
            end
         end
      end
   end

   // Response handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         rsp_trig_ff     <= pulse_act_ff;
         rsp_done_ff     <= running_ff && done_ff;
         rsp_total_ff    <= completed_ff;
         rsp_conflict_ff <= running_ff ? conflict_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_conflict_ff, rsp_total_ff, rsp_done_ff, rsp_trig_ff};

endmodule
